[hw/rtl/i2c_master_write_read_top_defines.svh]
// ----------------------------------------------------------------------------
// I2C master assertion macros
// Shared property wrappers for the block's checker.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_WRITE_READ_TOP_DEFINES_SVH
`define I2C_MASTER_WRITE_READ_TOP_DEFINES_SVH

// plain implication, checked out of reset
`define I2CM_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("i2cm assertion failed");

// a stalled request keeps its valid and payload
`define I2CM_ASSERT_HOLD(name, clk, rst_n, vld, rdy, sig) \
  name: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && !rdy) |=> (vld && $stable(sig))) \
    else $error("i2cm stalled request changed");

`endif

[hw/rtl/i2cm_pkg.sv]
// ----------------------------------------------------------------------------
// I2C master package
// Types, codes and constants shared by the I2C master write/read block.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int TxDepth = 16;
  localparam int TxAw    = (TxDepth > 1) ? $clog2(TxDepth) : 1;
  localparam int LpW     = $clog2(TxDepth + 1);

  localparam logic [7:0] PhaseLenReset = 8'd35;

  typedef enum logic [1:0] {
    ActLoad  = 2'd0,
    ActStart = 2'd1,
    ActTick  = 2'd2
  } action_e;

  typedef enum logic [3:0] {
    PhIdle      = 4'd0,
    PhStart     = 4'd1,
    PhWbLow     = 4'd2,
    PhWbHigh    = 4'd3,
    PhAckLow    = 4'd4,
    PhAckHigh   = 4'd5,
    PhAckTail   = 4'd6,
    PhRbLow     = 4'd7,
    PhRbHigh    = 4'd8,
    PhMackLow   = 4'd9,
    PhMackHigh  = 4'd10,
    PhMackTail  = 4'd11,
    PhStopLow   = 4'd12,
    PhStopHigh  = 4'd13,
    PhEstopLow  = 4'd14,
    PhEstopHigh = 4'd15
  } phase_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
    logic [4:0] tx_count;
    logic [7:0] rx_count;
    logic       length_from_first;
    logic       sda_in;
  } req_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic       nack_error;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rx_last;
  } res_item_t;

endpackage

[hw/rtl/i2cm_channels.sv]
// ----------------------------------------------------------------------------
// I2C master channels
// Valid/ready channel interfaces for requests, results and configuration.
// ----------------------------------------------------------------------------
interface i2cm_req_if;
  import i2cm_pkg::*;
  logic      valid;
  logic      ready;
  req_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface i2cm_res_if;
  import i2cm_pkg::*;
  logic      valid;
  logic      ready;
  res_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface i2cm_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] phase_length;
  modport source (output valid, output phase_length, input ready);
  modport sink (input valid, input phase_length, output ready);
endinterface

[hw/rtl/i2cm_outbuf.sv]
// ----------------------------------------------------------------------------
// I2C master result buffer
// Two-entry result queue that decouples the core from output backpressure.
// ----------------------------------------------------------------------------
module i2cm_outbuf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  i2cm_pkg::res_item_t wr_data_i,
  output logic                wr_ready_o,
  i2cm_res_if.source          res_o
);
  import i2cm_pkg::*;

  res_item_t  mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wr_ptr_q, rd_ptr_q;
  logic       pop;

  assign pop         = res_o.valid && res_o.ready;
  assign wr_ready_o  = (cnt_q != 2'd2) || res_o.ready;
  assign res_o.valid = (cnt_q != 2'd0);
  assign res_o.payload = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q + {1'b0, wr_en_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_en_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

endmodule

[hw/rtl/i2cm_core.sv]
// ----------------------------------------------------------------------------
// I2C master core
// Transmit buffer, bus phase sequencer and line levels for one request.
// ----------------------------------------------------------------------------
module i2cm_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_vld_i,
  input  i2cm_pkg::req_item_t item_i,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_data_i,
  output i2cm_pkg::res_item_t res_o
);
  import i2cm_pkg::*;

  logic [7:0]     tx_buf [TxDepth];

  phase_e         phase_q, phase_d;
  logic [7:0]     timer_q, timer_d;
  logic [2:0]     bit_cnt_q, bit_cnt_d;
  logic [8:0]     byte_idx_q, byte_idx_d;
  logic [7:0]     shift_q, shift_d;
  logic [LpW-1:0] wr_total_q, wr_total_d;
  logic [7:0]     rd_total_q, rd_total_d;
  logic           len_pend_q, len_pend_d;
  logic [LpW-1:0] load_ptr_q, load_ptr_d;
  logic [7:0]     phase_len_q;

  logic           load_we;
  logic [8:0]     byte_nxt;
  logic [8:0]     rd_idx;
  logic [TxAw-1:0] rd_addr;
  logic [7:0]     tx_rdata_q;
  logic [7:0]     timer_inc;
  logic [7:0]     limit;
  logic [7:0]     shift_in;
  logic           rx_v, rx_l, done, err;
  logic [7:0]     rx_b;
  logic           scl, drv, lvl, nacks;

  assign byte_nxt = byte_idx_q + 9'd1;
  assign rd_idx   = byte_idx_d + 9'd1;
  assign rd_addr  = (phase_d == PhStart) ? '0 : rd_idx[TxAw-1:0];
  assign timer_inc = timer_q + 8'd1;
  assign limit    = (phase_len_q == 8'd0) ? 8'd1 : phase_len_q;
  assign shift_in = {shift_q[6:0], item_i.sda_in};
  assign load_we  = item_vld_i && (item_i.action == ActLoad) && (phase_q == PhIdle)
                    && (int'(load_ptr_q) < TxDepth);

  always_comb begin
    phase_d    = phase_q;
    timer_d    = timer_q;
    bit_cnt_d  = bit_cnt_q;
    byte_idx_d = byte_idx_q;
    shift_d    = shift_q;
    wr_total_d = wr_total_q;
    rd_total_d = rd_total_q;
    len_pend_d = len_pend_q;
    load_ptr_d = load_ptr_q;
    rx_v       = 1'b0;
    rx_l       = 1'b0;
    rx_b       = 8'd0;
    done       = 1'b0;
    err        = 1'b0;

    if (item_vld_i) begin
      unique case (action_e'(item_i.action))
        ActLoad: begin
          if (load_we) begin
            load_ptr_d = load_ptr_q + LpW'(1);
          end
        end
        ActStart: begin
          if (phase_q == PhIdle) begin
            if (int'(item_i.tx_count) > TxDepth) begin
              wr_total_d = LpW'(TxDepth);
            end else begin
              wr_total_d = LpW'(item_i.tx_count);
            end
            rd_total_d = item_i.rx_count;
            len_pend_d = item_i.length_from_first;
            load_ptr_d = '0;
            byte_idx_d = 9'd0;
            bit_cnt_d  = 3'd0;
            shift_d    = 8'd0;
            timer_d    = 8'd0;
            phase_d    = PhStart;
          end
        end
        ActTick: begin
          if (phase_q != PhIdle) begin
            if (timer_inc >= limit) begin
              timer_d = 8'd0;
              unique case (phase_q)
                PhStart: begin
                  byte_idx_d = 9'd0;
                  bit_cnt_d  = 3'd0;
                  if (wr_total_q != '0) begin
                    shift_d = tx_rdata_q;
                    phase_d = PhWbLow;
                  end else begin
                    shift_d = 8'd0;
                    phase_d = (len_pend_q || rd_total_q != 8'd0) ? PhRbLow : PhStopLow;
                  end
                end
                PhWbLow:  phase_d = PhWbHigh;
                PhWbHigh: begin
                  shift_d = {shift_q[6:0], 1'b0};
                  if (bit_cnt_q == 3'd7) begin
                    bit_cnt_d = 3'd0;
                    phase_d   = PhAckLow;
                  end else begin
                    bit_cnt_d = bit_cnt_q + 3'd1;
                    phase_d   = PhWbLow;
                  end
                end
                PhAckLow:  phase_d = PhAckHigh;
                PhAckHigh: phase_d = item_i.sda_in ? PhEstopLow : PhAckTail;
                PhAckTail: begin
                  bit_cnt_d = 3'd0;
                  if (byte_nxt < 9'(wr_total_q)) begin
                    byte_idx_d = byte_nxt;
                    shift_d    = tx_rdata_q;
                    phase_d    = PhWbLow;
                  end else begin
                    byte_idx_d = 9'd0;
                    shift_d    = 8'd0;
                    phase_d    = (len_pend_q || rd_total_q != 8'd0) ? PhRbLow : PhStopLow;
                  end
                end
                PhRbLow:  phase_d = PhRbHigh;
                PhRbHigh: begin
                  shift_d = shift_in;
                  if (bit_cnt_q == 3'd7) begin
                    bit_cnt_d = 3'd0;
                    rx_v      = 1'b1;
                    rx_b      = shift_in;
                    if (len_pend_q) begin
                      rd_total_d = shift_in;
                      rx_l       = (shift_in <= 8'd1);
                    end else begin
                      rx_l = (byte_nxt >= {1'b0, rd_total_q});
                    end
                    phase_d = PhMackLow;
                  end else begin
                    bit_cnt_d = bit_cnt_q + 3'd1;
                    phase_d   = PhRbLow;
                  end
                end
                PhMackLow:  phase_d = PhMackHigh;
                PhMackHigh: begin
                  if (bit_cnt_q < 3'd2) begin
                    bit_cnt_d = bit_cnt_q + 3'd1;
                  end else begin
                    bit_cnt_d = 3'd0;
                    phase_d   = PhMackTail;
                  end
                end
                PhMackTail: begin
                  len_pend_d = 1'b0;
                  byte_idx_d = byte_nxt;
                  bit_cnt_d  = 3'd0;
                  shift_d    = 8'd0;
                  phase_d    = (byte_nxt < {1'b0, rd_total_q}) ? PhRbLow : PhStopLow;
                end
                PhStopLow:  phase_d = PhStopHigh;
                PhEstopLow: phase_d = PhEstopHigh;
                PhStopHigh, PhEstopHigh: begin
                  done    = 1'b1;
                  err     = (phase_q == PhEstopHigh);
                  phase_d = PhIdle;
                end
                PhIdle: phase_d = PhIdle;
              endcase
            end else begin
              timer_d = timer_inc;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    nacks = !len_pend_d && ((byte_idx_d + 9'd1) >= {1'b0, rd_total_d});
    scl   = 1'b0;
    drv   = 1'b1;
    lvl   = 1'b0;
    unique case (phase_d)
      PhIdle: begin
        scl = 1'b1;
        lvl = 1'b1;
      end
      PhStart:   scl = 1'b1;
      PhWbLow:   lvl = shift_d[7];
      PhWbHigh: begin
        scl = 1'b1;
        lvl = shift_d[7];
      end
      PhAckLow:  drv = 1'b0;
      PhAckHigh: begin
        scl = 1'b1;
        drv = 1'b0;
      end
      PhAckTail: lvl = 1'b0;
      PhRbLow:   drv = 1'b0;
      PhRbHigh: begin
        scl = 1'b1;
        drv = 1'b0;
      end
      PhMackLow:  lvl = nacks;
      PhMackHigh: begin
        scl = 1'b1;
        lvl = nacks;
      end
      PhMackTail: lvl = nacks;
      PhStopHigh, PhEstopHigh: scl = 1'b1;
      PhStopLow, PhEstopLow:   scl = 1'b0;
    endcase
  end

  always_comb begin
    res_o.scl_level  = scl;
    res_o.sda_drive  = drv;
    res_o.sda_level  = drv & lvl;
    res_o.busy_res   = (phase_d != PhIdle);
    res_o.done_res   = done;
    res_o.nack_error = err;
    res_o.rx_valid   = rx_v;
    res_o.rx_byte    = rx_b;
    res_o.rx_last    = rx_v & rx_l;
  end

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      tx_buf[load_ptr_q[TxAw-1:0]] <= item_i.data_byte;
    end
    tx_rdata_q <= tx_buf[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      timer_q     <= 8'd0;
      bit_cnt_q   <= 3'd0;
      byte_idx_q  <= 9'd0;
      shift_q     <= 8'd0;
      wr_total_q  <= '0;
      rd_total_q  <= 8'd0;
      len_pend_q  <= 1'b0;
      load_ptr_q  <= '0;
      phase_len_q <= PhaseLenReset;
    end else begin
      phase_q    <= phase_d;
      timer_q    <= timer_d;
      bit_cnt_q  <= bit_cnt_d;
      byte_idx_q <= byte_idx_d;
      shift_q    <= shift_d;
      wr_total_q <= wr_total_d;
      rd_total_q <= rd_total_d;
      len_pend_q <= len_pend_d;
      load_ptr_q <= load_ptr_d;
      if (cfg_we_i) begin
        phase_len_q <= cfg_data_i;
      end
    end
  end

endmodule

[hw/rtl/i2c_master_write_read_top.sv]
// A request is held in the input register, then its result goes into the result queue.
// Throughput: one request per cycle, held only by output backpressure.
// The input register and a two-entry result queue set that rate.
// Reset: asynchronous, active low; bus goes idle, phase length returns to 35.
// Transmit buffer contents are undefined after reset until loaded.
// ----------------------------------------------------------------------------
// I2C master write/read top level
// Input register, bus sequencer core and result queue.
// ----------------------------------------------------------------------------
module i2c_master_write_read_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  i2cm_req_if.sink   req_i,
  i2cm_cfg_if.sink   cfg_i,
  i2cm_res_if.source res_o
);
  import i2cm_pkg::*;

  req_item_t in_q;
  logic      in_vld_q, in_vld_d;
  logic      ob_ready;
  logic      go;
  res_item_t core_res;

  assign go          = in_vld_q && ob_ready;
  assign req_i.ready = !in_vld_q || ob_ready;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    in_vld_d = in_vld_q;
    if (req_i.valid && req_i.ready) begin
      in_vld_d = 1'b1;
    end else if (go) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q <= req_i.payload;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  i2cm_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_vld_i (go),
    .item_i     (in_q),
    .cfg_we_i   (cfg_i.valid),
    .cfg_data_i (cfg_i.phase_length),
    .res_o      (core_res)
  );

  i2cm_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (go),
    .wr_data_i  (core_res),
    .wr_ready_o (ob_ready),
    .res_o      (res_o)
  );

endmodule

[hw/rtl/i2cm_checker.sv]
// ----------------------------------------------------------------------------
// I2C master checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "i2c_master_write_read_top_defines.svh"

module i2cm_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                res_valid_i,
  input logic                res_ready_i,
  input i2cm_pkg::res_item_t res_i
);
  import i2cm_pkg::*;

  `I2CM_ASSERT(a_done_idle, clk_i, rst_ni, (res_valid_i && res_i.done_res) |-> !res_i.busy_res)
  `I2CM_ASSERT(a_err_done, clk_i, rst_ni, (res_valid_i && res_i.nack_error) |-> res_i.done_res)
  `I2CM_ASSERT(a_last_rx, clk_i, rst_ni, (res_valid_i && res_i.rx_last) |-> res_i.rx_valid)
  `I2CM_ASSERT(a_idle_lines, clk_i, rst_ni, (res_valid_i && !res_i.busy_res) |-> (res_i.scl_level && res_i.sda_drive && res_i.sda_level))
  `I2CM_ASSERT_HOLD(a_res_hold, clk_i, rst_ni, res_valid_i, res_ready_i, res_i)

endmodule

bind i2c_master_write_read_top i2cm_checker u_i2cm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_i       (res_o.payload)
);
